// ===== rtl/bilinear_upscale_4x_assert.svh =====
// Assertion macros for the 4x bilinear upscaler.
// Included by the top level; depends on nothing else.
`ifndef BILINEAR_UPSCALE_4X_ASSERT_SVH
`define BILINEAR_UPSCALE_4X_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BU4X_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bilinear_upscale_4x: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BU4X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bilinear_upscale_4x: assertion failed");

`endif

// ===== rtl/bu4x_pkg.sv =====
// Shared types, constants and the axis mapping function of the 4x upscaler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bu4x_pkg;

    localparam int BU4X_SRC_DIM = 128;
    localparam int PIX_W        = 8;
    localparam int COORD_W      = 9;
    // Wide enough for any output position of the largest supported image.
    localparam int POS_W        = 12;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_READ  = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        STEP_MID,
        STEP_QTR,
        STEP_EXT
    } t_step;

    typedef enum logic [2:0] {
        JOB_H0,
        JOB_H1,
        JOB_VA,
        JOB_VB,
        JOB_CX
    } t_job;

    typedef enum logic {
        ALU_AVG,
        ALU_EXT
    } t_alu_op;

    typedef struct packed {
        t_req_kind            kind;
        logic [COORD_W-1:0]   row;
        logic [COORD_W-1:0]   col;
        logic [PIX_W-1:0]     pixel;
    } t_req;

    typedef struct packed {
        logic [COORD_W-1:0]   col;
        logic [COORD_W-1:0]   row;
        logic [PIX_W-1:0]     pixel;
    } t_result;

    // One axis of a read: the two source indices, the quarter phase between
    // them and whether the position lies in the extrapolated border.
    typedef struct packed {
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        logic [1:0]       phase;
        logic             ext;
    } t_axis;

    function automatic t_axis bu4x_axis(input logic [POS_W-1:0] pos,
                                        input logic [POS_W-1:0] last_pos,
                                        input logic [POS_W-1:0] last_src);
        t_axis            ax;
        logic [POS_W-1:0] k;
        k = pos >> 2;
        if (pos > last_pos) begin
            // Border: mirror about the last source sample, taken from the
            // interpolation between the two last source samples.
            ax.lo    = last_src - POS_W'(1);
            ax.hi    = last_src;
            ax.phase = ~pos[1:0] + 2'd1;
            ax.ext   = 1'b1;
        end else begin
            ax.lo    = k;
            ax.hi    = (k == last_src) ? k : k + POS_W'(1);
            ax.phase = pos[1:0];
            ax.ext   = 1'b0;
        end
        return ax;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bu4x_alu.sv =====
// Shared arithmetic unit of the upscaler: truncated average or saturated
// point reflection of two pixels. Depends on bu4x_pkg.
`default_nettype none

module bu4x_alu import bu4x_pkg::*; (
    input  t_alu_op          i_op,
    input  logic [PIX_W-1:0] i_a,
    input  logic [PIX_W-1:0] i_b,
    output logic [PIX_W-1:0] o_y
);

    logic signed [PIX_W+1:0] w_diff;

    // 2a - b spans -255..510, which fits ten signed bits.
    assign w_diff = $signed({1'b0, i_a, 1'b0}) - $signed({2'b00, i_b});

    always_comb begin
        unique case (i_op)
            ALU_AVG: o_y = {1'b0, i_a[PIX_W-1:1]} + {1'b0, i_b[PIX_W-1:1]};
            ALU_EXT: begin
                if (w_diff[PIX_W+1]) begin
                    o_y = '0;
                end else if (w_diff[PIX_W]) begin
                    o_y = '1;
                end else begin
                    o_y = w_diff[PIX_W-1:0];
                end
            end
            default: o_y = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bu4x_ram.sv =====
// Single-port source image memory with a registered read.
// Depends on bu4x_pkg for the pixel width.
`default_nettype none

module bu4x_ram import bu4x_pkg::*; #(
    parameter int DEPTH = BU4X_SRC_DIM * BU4X_SRC_DIM,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [PIX_W-1:0] i_wdata,
    output logic [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bu4x_core.sv =====
// Sequencer of the upscaler: fetches a 2x2 source window, then runs the
// interpolation jobs through the shared unit. Depends on bu4x_pkg, bu4x_alu, bu4x_ram.
`default_nettype none

module bu4x_core import bu4x_pkg::*; #(
    parameter int SRC_DIM = BU4X_SRC_DIM
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_req    i_req,
    output logic    o_ready,
    output logic    o_done,
    output t_result o_result,
    input  logic    i_ack
);

    localparam int OUT_DIM  = 4 * SRC_DIM;
    localparam int LAST_POS = OUT_DIM - 4;
    localparam int SW       = $clog2(SRC_DIM);
    localparam int DEPTH    = SRC_DIM * SRC_DIM;
    localparam int AW       = $clog2(DEPTH);

    t_state r_state, n_state;
    t_step  r_step,  n_step;
    t_job   r_job,   n_job;
    logic [2:0] r_rd_idx, n_rd_idx;

    logic [COORD_W-1:0] r_row_echo, r_col_echo;
    t_axis              r_rax, r_cax;
    logic [PIX_W-1:0]   r_px [4];
    logic [PIX_W-1:0]   r_acc, r_h0, r_h1, r_va, r_vb, r_fin;

    logic [POS_W-1:0] w_row_pos, w_col_pos;
    t_axis            w_rax, w_cax;
    logic             w_wr_ok;
    logic [AW-1:0]    w_wr_addr, w_rd_addr;
    logic [SW-1:0]    w_rd_row, w_rd_col;

    logic             w_mem_we;
    logic [AW-1:0]    w_mem_addr;
    logic [PIX_W-1:0] w_mem_rdata;

    logic [PIX_W-1:0] w_x, w_y, w_val, w_alu_a, w_alu_b, w_alu_y;
    logic [1:0]       w_ph;
    logic             w_ext, w_finish;
    t_alu_op          w_alu_op;

    // Request decode: clamp read positions, map both axes, form addresses.
    always_comb begin
        w_row_pos = (POS_W'(i_req.row) >= POS_W'(OUT_DIM)) ?
                    POS_W'(OUT_DIM - 1) : POS_W'(i_req.row);
        w_col_pos = (POS_W'(i_req.col) >= POS_W'(OUT_DIM)) ?
                    POS_W'(OUT_DIM - 1) : POS_W'(i_req.col);
        w_rax = bu4x_axis(w_row_pos, POS_W'(LAST_POS), POS_W'(SRC_DIM - 1));
        w_cax = bu4x_axis(w_col_pos, POS_W'(LAST_POS), POS_W'(SRC_DIM - 1));
        w_wr_ok = (POS_W'(i_req.row) < POS_W'(SRC_DIM)) &&
                  (POS_W'(i_req.col) < POS_W'(SRC_DIM));
        w_wr_addr = AW'(SW'(i_req.row)) * AW'(SRC_DIM) + AW'(SW'(i_req.col));
        w_rd_row  = r_rd_idx[1] ? r_rax.hi[SW-1:0] : r_rax.lo[SW-1:0];
        w_rd_col  = r_rd_idx[0] ? r_cax.hi[SW-1:0] : r_cax.lo[SW-1:0];
        w_rd_addr = AW'(w_rd_row) * AW'(SRC_DIM) + AW'(w_rd_col);
    end

    bu4x_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (i_req.pixel),
        .o_rdata (w_mem_rdata)
    );

    bu4x_alu u_alu (
        .i_op (w_alu_op),
        .i_a  (w_alu_a),
        .i_b  (w_alu_b),
        .o_y  (w_alu_y)
    );

    // Outputs and datapath selection.
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        o_done     = (r_state == ST_DONE);
        w_mem_we   = (r_state == ST_IDLE) && i_start && (i_req.kind == REQ_WRITE) && w_wr_ok;
        w_mem_addr = (r_state == ST_IDLE) ? w_wr_addr : w_rd_addr;

        // Each job interpolates x toward y at a quarter phase and may then
        // reflect the result about y.
        unique case (r_job)
            JOB_H0:  begin w_x = r_px[0]; w_y = r_px[1]; w_ph = r_cax.phase; w_ext = 1'b0; end
            JOB_H1:  begin w_x = r_px[2]; w_y = r_px[3]; w_ph = r_cax.phase; w_ext = 1'b0; end
            JOB_VA:  begin w_x = r_h0;    w_y = r_h1;    w_ph = r_rax.phase; w_ext = r_rax.ext; end
            JOB_VB:  begin w_x = r_px[1]; w_y = r_px[3]; w_ph = r_rax.phase; w_ext = r_rax.ext; end
            JOB_CX:  begin w_x = r_va;    w_y = r_vb;    w_ph = 2'd0;        w_ext = 1'b1; end
            default: begin w_x = '0;      w_y = '0;      w_ph = 2'd0;        w_ext = 1'b0; end
        endcase

        unique case (r_step)
            STEP_MID: begin w_alu_op = ALU_AVG; w_alu_a = w_x; w_alu_b = w_y; end
            STEP_QTR: begin
                w_alu_op = ALU_AVG;
                w_alu_a  = w_ph[1] ? w_y : w_x;
                w_alu_b  = r_acc;
            end
            STEP_EXT: begin w_alu_op = ALU_EXT; w_alu_a = w_y; w_alu_b = r_acc; end
            default:  begin w_alu_op = ALU_AVG; w_alu_a = '0;  w_alu_b = '0;    end
        endcase

        w_val = (r_step == STEP_MID && w_ph == 2'd0) ? w_x : w_alu_y;
        w_finish = (r_state == ST_CALC) &&
                   ((r_step == STEP_EXT) ||
                    (r_step == STEP_QTR && !w_ext) ||
                    (r_step == STEP_MID && !w_ext && !w_ph[0]));

        o_result.pixel = r_cax.ext ? r_fin : r_va;
        o_result.row   = r_row_echo;
        o_result.col   = r_col_echo;
    end

    // Next state of the sequencer.
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_job    = r_job;
        n_rd_idx = r_rd_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_req.kind == REQ_READ) begin
                    n_state  = ST_READ;
                    n_rd_idx = 3'd0;
                end
            end
            ST_READ: begin
                n_rd_idx = r_rd_idx + 3'd1;
                if (r_rd_idx == 3'd4) begin
                    n_state = ST_CALC;
                    n_job   = JOB_H0;
                    n_step  = STEP_MID;
                end
            end
            ST_CALC: begin
                if (w_finish) begin
                    n_step = STEP_MID;
                    unique case (r_job)
                        JOB_H0:  n_job = JOB_H1;
                        JOB_H1:  n_job = JOB_VA;
                        JOB_VA: begin
                            if (r_cax.ext) begin
                                n_job = JOB_VB;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        JOB_VB:  n_job = JOB_CX;
                        JOB_CX:  n_state = ST_DONE;
                        default: n_state = ST_DONE;
                    endcase
                end else begin
                    priority if (r_step == STEP_MID && w_ph[0]) begin
                        n_step = STEP_QTR;
                    end else begin
                        n_step = STEP_EXT;
                    end
                end
            end
            ST_DONE: begin
                if (i_ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_MID;
            r_job    <= JOB_H0;
            r_rd_idx <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_job    <= n_job;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start && i_req.kind == REQ_READ) begin
            r_row_echo <= i_req.row;
            r_col_echo <= i_req.col;
            r_rax      <= w_rax;
            r_cax      <= w_cax;
        end
        if (r_state == ST_READ && r_rd_idx != 3'd0) begin
            r_px[2'(r_rd_idx - 3'd1)] <= w_mem_rdata;
        end
        if (r_state == ST_CALC) begin
            if (w_finish) begin
                unique case (r_job)
                    JOB_H0:  r_h0  <= w_val;
                    JOB_H1:  r_h1  <= w_val;
                    JOB_VA:  r_va  <= w_val;
                    JOB_VB:  r_vb  <= w_val;
                    JOB_CX:  r_fin <= w_val;
                    default: r_fin <= w_val;
                endcase
            end else begin
                r_acc <= w_val;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bilinear_upscale_4x.sv =====
// Top level of the 4x bilinear upscaler: stream ports and the output register.
// Depends on bu4x_pkg, bu4x_core and the assertion macros header.
`default_nettype none
`include "bilinear_upscale_4x_assert.svh"

// The block stores a SRC_DIM x SRC_DIM image of 8-bit pixels and answers reads
// of its 4x upscaled version. A transaction with tuser = 0 writes one source
// pixel at (row, col); writes outside the source image are dropped and no write
// returns a result. A transaction with tuser = 1 reads the upscaled pixel at
// output position (row, col) and returns exactly one result that echoes the
// requested row and column. Upscaled values are built horizontally first, then
// vertically: half positions are a/2 + b/2 with each term truncated, quarter
// positions average their two neighbors the same way. The last three output
// rows and columns are reflected about the last source sample as 2*p - q,
// saturated to 0..255; rows are reflected first, then columns. Read positions
// beyond the output image are clamped to its last row or column. Every source
// pixel a read depends on must have been written since reset. A write is taken
// while the block is idle. A read fetches a 2x2 window of source pixels through
// the single port of the image memory, then runs three to twelve steps of the
// shared average and reflection unit, the most for reads in the bottom right
// corner, then hands its result to the output register once that can take it
// and returns to idle, open for the next transaction.
// The input side is not ready while a read is in progress, but a finished
// result may wait in the output register while the next transaction is taken.
module bilinear_upscale_4x import bu4x_pkg::*; #(
    parameter int SRC_DIM = BU4X_SRC_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata fields from bit 0: row[8:0], col[17:9], pixel_in[25:18], zero pad
    input  logic [31:0] s_axis_tdata,
    // tuser fields from bit 0: req_type (0 write, 1 read)
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata fields from bit 0: pixel_out[7:0], out_row[16:8], out_col[25:17], zero pad
    output logic [31:0] m_axis_tdata
);

    t_req    w_req;
    logic    w_accept;
    logic    w_core_ready;
    logic    w_core_done;
    t_result w_core_result;
    logic    w_slot_free;
    logic    w_load;

    logic    r_m_valid;
    t_result r_m_data;

    // Unpack the input transaction.
    always_comb begin
        w_req.kind  = t_req_kind'(s_axis_tuser);
        w_req.row   = s_axis_tdata[8:0];
        w_req.col   = s_axis_tdata[17:9];
        w_req.pixel = s_axis_tdata[25:18];
    end

    assign s_axis_tready = w_core_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bu4x_core #(
        .SRC_DIM (SRC_DIM)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_req    (w_req),
        .o_ready  (w_core_ready),
        .o_done   (w_core_done),
        .o_result (w_core_result),
        .i_ack    (w_load)
    );

    // The output register takes a finished result whenever it is empty or
    // being drained in the same cycle; otherwise the core holds its result.
    assign w_slot_free = !r_m_valid || m_axis_tready;
    assign w_load      = w_core_done && w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data <= w_core_result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b000000, r_m_data};

    // The core never offers a result while it is open for a new request.
    `BU4X_ASSERT_NOW(a_ready_not_done, i_clk, i_rst_n, s_axis_tready, !w_core_done)

    // An accepted read keeps the input side closed in the next cycle.
    `BU4X_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n,
                      w_accept && s_axis_tuser, !s_axis_tready)

    // A finished result that cannot be handed over is held unchanged.
    `BU4X_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, w_core_done && !w_slot_free,
                      w_core_done && $stable(w_core_result))

    // The output register only fills from a finished core result.
    `BU4X_ASSERT_NOW(a_fill_from_core, i_clk, i_rst_n, $rose(r_m_valid), $past(w_core_done))

endmodule

`default_nettype wire
